@@ rtl/rcpom_pkg.sv @@
// Package for the RC pulse capture and override multiplexer.
// Holds the beat types, command and channel codes, register indexes and mapping constants.
// No dependencies; every module of the block imports it.
package rcpom_pkg;

  // Width of the free-running edge time.
  localparam int TIME_BITS = 32;

  // Command codes of an input beat; the last code is unused and dropped.
  localparam logic [1:0] CMD_EDGE   = 2'd0;
  localparam logic [1:0] CMD_AUTO   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Edge channel codes; the last code is unused and dropped.
  localparam logic [1:0] CH_STEER  = 2'd0;
  localparam logic [1:0] CH_THROT  = 2'd1;
  localparam logic [1:0] CH_ENGAGE = 2'd2;
  localparam logic [1:0] CH_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PULSE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_ENGAGE_THR  = 2'd1;

  localparam logic [15:0] PULSE_LIMIT_RESET = 16'd2000;
  localparam logic [15:0] ENGAGE_THR_RESET  = 16'd1700;

  // Servo angle limits in degrees.
  localparam logic [7:0] ST_IDLE = 8'd98;
  localparam logic [7:0] ST_MAX  = 8'd123;
  localparam logic [7:0] ST_MIN  = 8'd68;
  localparam logic [7:0] TH_IDLE = 8'd90;
  localparam logic [7:0] TH_MAX  = 8'd102;
  localparam logic [7:0] TH_MIN  = 8'd70;

  // Receiver pulse breakpoints in microseconds.
  localparam logic [15:0] RX_ST_IDLE_LO = 16'd1470;
  localparam logic [15:0] RX_ST_IDLE_HI = 16'd1530;
  localparam logic [15:0] RX_ST_OVR_LO  = 16'd1353;
  localparam logic [15:0] RX_ST_OVR_HI  = 16'd1647;
  localparam logic [15:0] RX_TH_IDLE_LO = 16'd1455;
  localparam logic [15:0] RX_TH_IDLE_HI = 16'd1515;
  localparam logic [15:0] RX_TH_OVR_LO  = 16'd1388;
  localparam logic [15:0] RX_TH_OVR_HI  = 16'd1582;

  // Input beat.
  typedef struct packed {
    logic [1:0]           cmd;
    logic [1:0]           channel;
    logic [TIME_BITS-1:0] timestamp_us;
    logic signed [15:0]   steering_rad;
    logic signed [7:0]    throttle_cmd;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] steering_angle;
    logic [7:0] throttle_angle;
    logic       engaged;
    logic       override_steer;
    logic       override_throt;
  } out_item_t;

  // Classified work item passed from the front to the back.
  typedef struct packed {
    logic [1:0]           op;
    logic [1:0]           channel;
    logic [TIME_BITS-1:0] timestamp_us;
    logic [7:0]           auto_steer;
    logic [7:0]           auto_throt;
  } q_item_t;

endpackage

@@ rtl/rcpom_front.sv @@
// Front end: accepts input beats, drops ignored codes and maps autonomous commands.
// Depends on rcpom_pkg.
module rcpom_front import rcpom_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_ready,
  output logic     q_push,
  output q_item_t  q_wdata
);

  localparam logic signed [15:0] SAT_POS = 16'sd1229;
  localparam logic signed [15:0] SAT_NEG = -16'sd1229;
  localparam logic signed [7:0]  TH_SAT_POS = 8'sd100;
  localparam logic signed [7:0]  TH_SAT_NEG = -8'sd100;

  logic        keep;
  logic [15:0] neg_s;
  logic [17:0] st_prod;
  logic [6:0]  st_y;
  logic [14:0] st_q3;
  logic [14:0] st_neg_num;
  logic [7:0]  auto_st;
  logic [7:0]  neg_t;
  logic [8:0]  th_x3;
  logic [15:0] th_pos_prod;
  logic [7:0]  th_u4;
  logic [15:0] th_neg_prod;
  logic [7:0]  auto_th;

  // Edges on the unused channel and the unused command code are dropped here.
  always_comb begin
    keep = 1'b0;
    case (in_data.cmd)
      CMD_EDGE: keep = (in_data.channel != CH_UNUSED);
      CMD_AUTO: keep = 1'b1;
      CMD_TICK: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  // Autonomous steering: negated, saturated at 0.3 rad, two linear segments.
  always_comb begin
    neg_s      = 16'(-in_data.steering_rad);
    st_prod    = 18'(neg_s[10:0]) * 18'd125;
    st_y       = st_prod[17:11];
    st_q3      = 15'(st_y) * 15'd86;
    st_neg_num = 15'(in_data.steering_rad[10:0]) * 15'd25 + 15'd1023;
    if (in_data.steering_rad <= SAT_NEG) begin
      auto_st = ST_MAX;
    end else if (in_data.steering_rad >= SAT_POS) begin
      auto_st = ST_MIN;
    end else if (in_data.steering_rad <= 16'sd0) begin
      auto_st = ST_IDLE + 8'(st_q3[14:8]);
    end else begin
      auto_st = ST_IDLE - 8'(st_neg_num[14:10]);
    end
  end

  // Autonomous throttle: saturated at 100 units, two linear segments.
  always_comb begin
    neg_t       = 8'(-in_data.throttle_cmd);
    th_x3       = 9'(in_data.throttle_cmd[6:0]) * 9'd3;
    th_pos_prod = 16'(th_x3) * 16'd41;
    th_u4       = 8'(neg_t[6:0]) + 8'd4;
    th_neg_prod = 16'(th_u4) * 16'd205;
    if (in_data.throttle_cmd >= TH_SAT_POS) begin
      auto_th = TH_MAX;
    end else if (in_data.throttle_cmd <= TH_SAT_NEG) begin
      auto_th = TH_MIN;
    end else if (in_data.throttle_cmd >= 8'sd0) begin
      auto_th = TH_IDLE + 8'(th_pos_prod[15:10]);
    end else begin
      auto_th = TH_IDLE - 8'(th_neg_prod[15:10]);
    end
  end

  assign in_ready             = q_ready;
  assign q_push               = in_valid && q_ready && keep;
  assign q_wdata.op           = in_data.cmd;
  assign q_wdata.channel      = in_data.channel;
  assign q_wdata.timestamp_us = in_data.timestamp_us;
  assign q_wdata.auto_steer   = auto_st;
  assign q_wdata.auto_throt   = auto_th;

endmodule

@@ rtl/rcpom_queue.sv @@
// Two-entry queue of classified work items between the front and the back.
// Depends on rcpom_pkg.
module rcpom_queue import rcpom_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wdata,
  output logic    push_ready,
  output logic    rd_valid,
  output q_item_t rdata,
  input  logic    pop
);

  q_item_t    entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign push_ready = (count_r != 2'd2);
  assign rd_valid   = (count_r != 2'd0);
  assign rdata      = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/rcpom_back.sv @@
// Back end: pulse capture state, configuration registers, tick mapping and output register.
// Depends on rcpom_pkg.
module rcpom_back import rcpom_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  q_item_t     q_rdata,
  output logic        q_pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [TIME_BITS-1:0] last_edge_r [3];
  logic [15:0]          steer_pulse_r;
  logic [15:0]          throt_pulse_r;
  logic                 engaged_r;
  logic [7:0]           auto_steer_r;
  logic [7:0]           auto_throt_r;
  logic [15:0]          pulse_limit_r;
  logic [15:0]          engage_thr_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic                 is_edge;
  logic                 is_auto;
  logic                 is_tick;
  logic                 out_free;
  logic [TIME_BITS-1:0] dt;
  logic                 dt_ok;
  logic                 dt_engage;

  logic [15:0] st_d;
  logic [17:0] st_hi_prod;
  logic [15:0] st_e;
  logic [9:0]  st_x;
  logic [23:0] st_lo_prod;
  logic [7:0]  st_rx;
  logic [15:0] th_d;
  logic [9:0]  th_x;
  logic [19:0] th_hi_prod;
  logic [15:0] th_e;
  logic [12:0] th_xl;
  logic [24:0] th_lo_prod;
  logic [7:0]  th_rx;
  logic        ov_s;
  logic        ov_t;
  out_item_t   res;

  // Work item decode and pop: a tick waits for room in the output register.
  assign is_edge   = (q_rdata.op == CMD_EDGE);
  assign is_auto   = (q_rdata.op == CMD_AUTO);
  assign is_tick   = (q_rdata.op == CMD_TICK);
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = q_valid && (!is_tick || out_free);
  assign cfg_ready = 1'b1;

  // Edge interval against the previous edge of the same channel.
  always_comb begin
    dt        = q_rdata.timestamp_us - last_edge_r[q_rdata.channel];
    dt_ok     = dt < TIME_BITS'(pulse_limit_r);
    dt_engage = dt > TIME_BITS'(engage_thr_r);
  end

  // Receiver steering mapping with deadband, already clamped to the servo range.
  always_comb begin
    st_d       = steer_pulse_r - RX_ST_IDLE_HI;
    st_hi_prod = 18'(st_d[8:0]) * 18'd293;
    st_e       = RX_ST_IDLE_LO - steer_pulse_r;
    st_x       = 10'(st_e[8:0]) * 10'd3 + 10'd28;
    st_lo_prod = 24'(st_x) * 24'd565;
    if (steer_pulse_r > RX_ST_IDLE_LO && steer_pulse_r < RX_ST_IDLE_HI) begin
      st_rx = ST_IDLE;
    end else if (steer_pulse_r >= RX_ST_IDLE_HI) begin
      st_rx = (st_d >= 16'd350) ? ST_MAX : ST_IDLE + 8'(st_hi_prod[17:12]);
    end else begin
      st_rx = (st_e >= 16'd290) ? ST_MIN : ST_IDLE - 8'(st_lo_prod[23:14]);
    end
  end

  // Receiver throttle mapping with deadband, already clamped to the servo range.
  always_comb begin
    th_d       = throt_pulse_r - RX_TH_IDLE_HI;
    th_x       = 10'(th_d[7:0]) * 10'd4;
    th_hi_prod = 20'(th_x) * 20'd979;
    th_e       = RX_TH_IDLE_LO - throt_pulse_r;
    th_xl      = 13'(th_e[8:0]) * 13'd20 + 13'd362;
    th_lo_prod = 25'(th_xl) * 25'd2889;
    if (throt_pulse_r > RX_TH_IDLE_LO && throt_pulse_r < RX_TH_IDLE_HI) begin
      th_rx = TH_IDLE;
    end else if (throt_pulse_r >= RX_TH_IDLE_HI) begin
      th_rx = (th_d >= 16'd201) ? TH_MAX : TH_IDLE + 8'(th_hi_prod[19:16]);
    end else begin
      th_rx = (th_e >= 16'd363) ? TH_MIN : TH_IDLE - 8'(th_lo_prod[24:20]);
    end
  end

  // Override detection and source selection.
  always_comb begin
    ov_s = (steer_pulse_r < RX_ST_OVR_LO) || (steer_pulse_r > RX_ST_OVR_HI);
    ov_t = (throt_pulse_r < RX_TH_OVR_LO) || (throt_pulse_r > RX_TH_OVR_HI);
    res.engaged        = engaged_r;
    res.override_steer = ov_s;
    res.override_throt = ov_t;
    if (!engaged_r) begin
      res.steering_angle = st_rx;
      res.throttle_angle = th_rx;
    end else if (ov_s) begin
      res.steering_angle = st_rx;
      res.throttle_angle = auto_throt_r;
    end else if (ov_t) begin
      res.steering_angle = auto_steer_r;
      res.throttle_angle = th_rx;
    end else begin
      res.steering_angle = auto_steer_r;
      res.throttle_angle = auto_throt_r;
    end
  end

  // Capture state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r[0] <= '0;
      last_edge_r[1] <= '0;
      last_edge_r[2] <= '0;
      steer_pulse_r  <= '0;
      throt_pulse_r  <= '0;
      engaged_r      <= 1'b0;
      auto_steer_r   <= ST_IDLE;
      auto_throt_r   <= TH_IDLE;
      pulse_limit_r  <= PULSE_LIMIT_RESET;
      engage_thr_r   <= ENGAGE_THR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PULSE_LIMIT: pulse_limit_r <= cfg_wdata;
          CFG_ENGAGE_THR:  engage_thr_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (q_pop && is_edge) begin
        last_edge_r[q_rdata.channel] <= q_rdata.timestamp_us;
        if (dt_ok) begin
          case (q_rdata.channel)
            CH_STEER:  steer_pulse_r <= dt[15:0];
            CH_THROT:  throt_pulse_r <= dt[15:0];
            CH_ENGAGE: engaged_r     <= dt_engage;
            default: ;
          endcase
        end
      end
      if (q_pop && is_auto) begin
        auto_steer_r <= q_rdata.auto_steer;
        auto_throt_r <= q_rdata.auto_throt;
      end
    end
  end

  // Output register: loads a tick result, clears when the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && is_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && is_tick) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/rc_pulse_capture_override_mux.sv @@
// RC pulse capture with autonomous override multiplexer: top level.
// Instantiates rcpom_front, rcpom_queue and rcpom_back; depends on rcpom_pkg.
//
// Usage:
//   The input channel (in_valid, in_ready, in_data) takes one beat per cycle while the
//   queue has room: an edge event, an autonomous command or an update tick. Edges and
//   commands update internal state and give no result; each tick gives exactly one
//   result beat on the output channel (out_valid, out_ready, out_data) with both
//   servo angles and status flags. Beats with the unused command code, and edges on
//   the unused channel, are dropped. The configuration channel (cfg_valid, cfg_ready,
//   cfg_index, cfg_wdata) is always ready and writes the pulse limit (index 0) or the
//   engage threshold (index 1); write it only while the block is idle.
//   Result path: a tick passes through a queue entry and then the output register; it
//   waits in the queue while the output register holds a result not yet taken.
//   Throughput: one beat per cycle sustained while the receiver takes results; the
//   front maps commands combinationally and the back handles each edge and tick as it is popped.
//   Reset (synchronous, active low) clears the queue, the output register, the edge
//   times and pulses, the engaged flag, and restores idle autonomous angles and the
//   register defaults.
//   When the receiver stalls, the output register holds the result, the two-entry queue
//   fills with following beats, and in_ready drops once it is full.
module rc_pulse_capture_override_mux import rcpom_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic    q_ready;
  logic    q_push;
  q_item_t q_wdata;
  logic    q_valid;
  q_item_t q_rdata;
  logic    q_pop;

  rcpom_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rcpom_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .push_ready (q_ready),
    .rd_valid   (q_valid),
    .rdata      (q_rdata),
    .pop        (q_pop)
  );

  rcpom_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
